// ----- hdl/imh_pkg.sv -----
package imh_pkg;

  localparam int unsigned CAPACITY     = 1024;
  localparam int unsigned HANDLE_COUNT = 1024;
  localparam int unsigned SLOT_W       = $clog2(CAPACITY);
  localparam int unsigned CNT_W        = $clog2(CAPACITY + 1);
  localparam int unsigned HANDLE_W     = 10;
  localparam int unsigned HIDX_W       = $clog2(HANDLE_COUNT);
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned ENTRY_W      = VALUE_W + HIDX_W;

  localparam logic [1:0] OP_PUSH     = 2'd0;
  localparam logic [1:0] OP_EXTRACT  = 2'd1;
  localparam logic [1:0] OP_DECREASE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic [1:0]          op;
    logic signed [31:0]  value;
    logic [HANDLE_W-1:0] handle;
  } request_t;

  typedef struct packed {
    logic signed [31:0] min_value;
    logic [1:0]         status;
  } result_t;

  // Biased value on top, handle below: unsigned compare orders by value, then handle.
  typedef struct packed {
    logic [VALUE_W-1:0] key;
    logic [HIDX_W-1:0]  hnd;
  } entry_t;

endpackage

// ----- hdl/indexed_min_heap_decrease_key.sv -----
// Channel   Signals                  Direction  Handshake
// request   start, req (request_t)   in         taken when start && !busy
// result    done, res (result_t)     out        one-cycle strobe, no stall
//
// After reset busy stays high for a pass that clears one presence bit per cycle,
// through all HANDLE_COUNT (1024) handles, before the first request is taken.
// A request keeps busy high through check and finish when rejected or unused, else
// through setup and finish plus a read, compare and two writes of slots and map
// entries per level sifted up, and two reads, compare and two writes per level
// sifted down; the longest is a decrease at the root of a full heap, ten levels down.
// busy drops in the cycle done is raised; the next request can be taken at its end.
// The single read port of the heap memory sets the pace.
module indexed_min_heap_decrease_key (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  imh_pkg::request_t req,
  output logic              busy,
  output logic              done,
  output imh_pkg::result_t  res
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_MAPRD, S_MAPWT, S_LOAD, S_UPRD, S_UPCMP,
    S_DNRDL, S_DNRDR, S_DNCMP, S_SWAP, S_FINISH
  } state_t;

  state_t state;
  logic up_mode, did_up, dec_mode;
  logic [imh_pkg::CNT_W-1:0]   count;
  logic [imh_pkg::SLOT_W-1:0]  cur, oth;
  imh_pkg::entry_t             cur_e, oth_e, left_e;
  logic                        left_only;
  imh_pkg::request_t           rq;

  // heap memory
  logic                        h_we;
  logic [imh_pkg::SLOT_W-1:0]  h_wa, h_ra;
  imh_pkg::entry_t             h_wd, h_rd;
  // position map
  logic                        m_we;
  logic [imh_pkg::HIDX_W-1:0]  m_wa, m_ra;
  logic [imh_pkg::SLOT_W-1:0]  m_wd, m_rd;
  // presence
  logic p_set, p_clr, p_bit, p_ready;
  logic [imh_pkg::HIDX_W-1:0] p_clr_idx;

  logic swap_phase;

  imh_ram #(.WIDTH(imh_pkg::ENTRY_W), .DEPTH(imh_pkg::CAPACITY)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
  );
  imh_ram #(.WIDTH(imh_pkg::SLOT_W), .DEPTH(imh_pkg::HANDLE_COUNT)) u_map (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd)
  );
  imh_present u_present (
    .clk(clk), .rst(rst), .set(p_set), .set_idx(rq.handle[imh_pkg::HIDX_W-1:0]),
    .clr(p_clr), .clr_idx(p_clr_idx), .rd_idx(req.handle[imh_pkg::HIDX_W-1:0]),
    .rd_bit(p_bit), .ready(p_ready)
  );

  logic [imh_pkg::SLOT_W:0] lchild, rchild;
  assign lchild = {cur, 1'b1};
  assign rchild = {cur, 1'b1} + 1'b1;

  function automatic imh_pkg::entry_t pack(input logic [31:0] v,
                                           input logic [imh_pkg::HIDX_W-1:0] h);
    imh_pkg::entry_t e;
    e.key = v ^ 32'h8000_0000;
    e.hnd = h;
    return e;
  endfunction

  always_comb begin
    h_we = 1'b0; h_wa = cur; h_wd = cur_e; h_ra = cur;
    m_we = 1'b0; m_wa = cur_e.hnd; m_wd = cur; m_ra = rq.handle[imh_pkg::HIDX_W-1:0];
    p_set = 1'b0; p_clr = 1'b0; p_clr_idx = left_e.hnd;
    case (state)
      S_IDLE: begin
        m_ra = req.handle[imh_pkg::HIDX_W-1:0];
        h_ra = '0;
      end
      S_CHECK: h_ra = '0;
      S_MAPRD: h_ra = imh_pkg::SLOT_W'(count - 1'b1);
      S_UPRD:  h_ra = (cur - 1'b1) >> 1;
      S_DNRDL: h_ra = lchild[imh_pkg::SLOT_W-1:0];
      S_DNRDR: h_ra = rchild[imh_pkg::SLOT_W-1:0];
      S_SWAP: begin
        h_we = 1'b1; m_we = 1'b1;
        if (!swap_phase) begin
          h_wa = cur; h_wd = oth_e; m_wa = oth_e.hnd; m_wd = cur;
        end else begin
          h_wa = oth; h_wd = cur_e; m_wa = cur_e.hnd; m_wd = oth;
        end
      end
      S_LOAD: begin
        h_we = 1'b1; m_we = 1'b1;
        h_wa = cur; h_wd = cur_e; m_wa = cur_e.hnd; m_wd = cur;
      end
      default: ;
    endcase
    if (state == S_LOAD && rq.op == imh_pkg::OP_PUSH) p_set = 1'b1;
    if (state == S_MAPWT && rq.op == imh_pkg::OP_EXTRACT) p_clr = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; count <= '0; busy <= 1'b1; done <= 1'b0;
      swap_phase <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        // hold off requests until the presence bits are cleared
        S_CLEAR: begin
          if (p_ready) begin
            busy <= 1'b0; state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            rq <= req; res <= '0; busy <= 1'b1; did_up <= 1'b0;
            dec_mode <= 1'b0; swap_phase <= 1'b0; state <= S_CHECK;
          end
        end
        // presence bit and root data arrive
        S_CHECK: begin
          case (rq.op)
            imh_pkg::OP_PUSH: begin
              if (count >= imh_pkg::CNT_W'(imh_pkg::CAPACITY)) begin
                res.status <= imh_pkg::ST_FULL; state <= S_FINISH;
              end else if (p_bit) begin
                res.status <= imh_pkg::ST_ABSENT; state <= S_FINISH;
              end else begin
                cur <= count[imh_pkg::SLOT_W-1:0];
                cur_e <= pack(rq.value, rq.handle[imh_pkg::HIDX_W-1:0]);
                count <= count + 1'b1; up_mode <= 1'b1; state <= S_LOAD;
              end
            end
            imh_pkg::OP_EXTRACT: begin
              if (count == '0) begin
                res.status <= imh_pkg::ST_EMPTY; state <= S_FINISH;
              end else state <= S_MAPRD;
            end
            imh_pkg::OP_DECREASE: begin
              if (!p_bit) begin
                res.status <= imh_pkg::ST_ABSENT; state <= S_FINISH;
              end else begin
                dec_mode <= 1'b1; state <= S_MAPRD;
              end
            end
            default: state <= S_FINISH;
          endcase
        end
        // root data (extract) or map entry (decrease) arrives
        S_MAPRD: begin
          if (rq.op == imh_pkg::OP_EXTRACT) begin
            res.min_value <= signed'(h_rd.key ^ 32'h8000_0000);
            left_e <= h_rd;
            count <= count - 1'b1;
          end
          state <= S_MAPWT;
        end
        S_MAPWT: begin
          if (rq.op == imh_pkg::OP_EXTRACT) begin
            if (count == '0) state <= S_FINISH;
            else begin
              cur <= '0; cur_e <= h_rd; up_mode <= 1'b0; state <= S_LOAD;
            end
          end else begin
            cur <= m_rd;
            cur_e <= pack(rq.value, rq.handle[imh_pkg::HIDX_W-1:0]);
            up_mode <= 1'b1; state <= S_LOAD;
          end
        end
        S_LOAD: state <= up_mode ? S_UPRD : S_DNRDL;
        S_UPRD: begin
          if (cur == '0) begin
            if (dec_mode) begin up_mode <= 1'b0; state <= S_DNRDL; end
            else state <= S_FINISH;
          end else begin
            oth <= (cur - 1'b1) >> 1; state <= S_UPCMP;
          end
        end
        S_UPCMP: begin
          if (cur_e < h_rd) begin
            oth_e <= h_rd; did_up <= 1'b1; state <= S_SWAP;
          end else if (dec_mode && !did_up) begin
            up_mode <= 1'b0; state <= S_DNRDL;
          end else state <= S_FINISH;
        end
        S_DNRDL: begin
          if ({1'b0, lchild} >= (imh_pkg::SLOT_W + 2)'(count)) state <= S_FINISH;
          else begin
            left_only <= ({1'b0, rchild} >= (imh_pkg::SLOT_W + 2)'(count));
            state <= S_DNRDR;
          end
        end
        S_DNRDR: begin
          left_e <= h_rd; state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (!left_only && h_rd < left_e) begin
            oth <= rchild[imh_pkg::SLOT_W-1:0]; oth_e <= h_rd;
          end else begin
            oth <= lchild[imh_pkg::SLOT_W-1:0]; oth_e <= left_e;
          end
          if ((!left_only && h_rd < left_e) ? (h_rd < cur_e) : (left_e < cur_e))
            state <= S_SWAP;
          else state <= S_FINISH;
        end
        S_SWAP: begin
          swap_phase <= ~swap_phase;
          if (swap_phase) begin
            cur <= oth;
            state <= up_mode ? S_UPRD : S_DNRDL;
          end
        end
        S_FINISH: begin
          done <= 1'b1; busy <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_busy_done: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("busy with done");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= imh_pkg::CNT_W'(imh_pkg::CAPACITY)) else $error("count overflow");

endmodule

// ----- hdl/imh_ram.sv -----
module imh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/imh_present.sv -----
// Presence bits, one RAM entry per handle; a pass after reset clears every entry.
module imh_present (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         set,
  input  logic [imh_pkg::HIDX_W-1:0]   set_idx,
  input  logic                         clr,
  input  logic [imh_pkg::HIDX_W-1:0]   clr_idx,
  input  logic [imh_pkg::HIDX_W-1:0]   rd_idx,
  output logic                         rd_bit,
  output logic                         ready
);

  logic                       wiping;
  logic [imh_pkg::HIDX_W-1:0] wipe_idx;
  logic                       we;
  logic [imh_pkg::HIDX_W-1:0] wa;
  logic                       wbit;

  always_ff @(posedge clk) begin
    if (rst) begin
      wiping <= 1'b1;
      wipe_idx <= '0;
    end else if (wiping) begin
      wipe_idx <= wipe_idx + 1'b1;
      if (wipe_idx == imh_pkg::HIDX_W'(imh_pkg::HANDLE_COUNT - 1)) begin
        wiping <= 1'b0;
      end
    end
  end

  always_comb begin
    we = set | clr | wiping;
    wbit = set & ~wiping;
    if (wiping) begin
      wa = wipe_idx;
    end else if (set) begin
      wa = set_idx;
    end else begin
      wa = clr_idx;
    end
  end

  imh_ram #(.WIDTH(1), .DEPTH(imh_pkg::HANDLE_COUNT)) u_bits (
    .clk(clk), .we(we), .waddr(wa), .wdata(wbit), .raddr(rd_idx), .rdata(rd_bit)
  );

  assign ready = ~wiping;

endmodule

// ----- tb/tb_indexed_min_heap_decrease_key.sv -----
`timescale 1ns / 1ps

module tb_indexed_min_heap_decrease_key;

  localparam int unsigned STALL_LIMIT = 20000;

  logic              clk;
  logic              rst;
  logic              start;
  imh_pkg::request_t req;
  logic              busy;
  logic              done;
  imh_pkg::result_t  res;

  indexed_min_heap_decrease_key u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .res  (res)
  );

  // Predictor state: biased-key entries, slot per handle, presence, size.
  logic [63:0] heap_q [imh_pkg::CAPACITY];
  int unsigned slot_of [imh_pkg::HANDLE_COUNT];
  bit          present [imh_pkg::HANDLE_COUNT];
  int unsigned heap_size;

  imh_pkg::result_t expected_results [$];
  int      error_count;
  int      request_count;
  int      result_count;
  int      extract_count;
  int      idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] make_entry(logic signed [31:0] v, logic [9:0] h);
    return {(v ^ 32'h8000_0000), 22'd0, h};
  endfunction

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic [63:0] t;
    t = heap_q[a];
    heap_q[a] = heap_q[b];
    heap_q[b] = t;
    slot_of[heap_q[a][9:0]] = a;
    slot_of[heap_q[b][9:0]] = b;
  endfunction

  function automatic int unsigned bubble_up(int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (heap_q[i] >= heap_q[p]) break;
      swap_entries(i, p);
      i = p;
    end
    return i;
  endfunction

  function automatic void bubble_down(int unsigned i);
    int unsigned l;
    int unsigned k;
    forever begin
      l = 2 * i + 1;
      if (l >= heap_size) break;
      k = l;
      if (l + 1 < heap_size && heap_q[l + 1] < heap_q[l]) k = l + 1;
      if (heap_q[k] >= heap_q[i]) break;
      swap_entries(i, k);
      i = k;
    end
  endfunction

  function automatic imh_pkg::result_t predict_heap_op(imh_pkg::request_t r);
    imh_pkg::result_t o;
    logic [63:0] root;
    o = '0;
    o.status = imh_pkg::ST_OK;
    if (r.op == imh_pkg::OP_PUSH) begin
      if (heap_size >= imh_pkg::CAPACITY) o.status = imh_pkg::ST_FULL;
      else if (present[r.handle]) o.status = imh_pkg::ST_ABSENT;
      else begin
        heap_q[heap_size] = make_entry(r.value, r.handle);
        slot_of[r.handle] = heap_size;
        present[r.handle] = 1'b1;
        heap_size++;
        void'(bubble_up(heap_size - 1));
      end
    end else if (r.op == imh_pkg::OP_EXTRACT) begin
      if (heap_size == 0) o.status = imh_pkg::ST_EMPTY;
      else begin
        root = heap_q[0];
        o.min_value = root[63:32] ^ 32'h8000_0000;
        present[root[9:0]] = 1'b0;
        heap_size--;
        if (heap_size > 0) begin
          heap_q[0] = heap_q[heap_size];
          slot_of[heap_q[0][9:0]] = 0;
          bubble_down(0);
        end
      end
    end else if (r.op == imh_pkg::OP_DECREASE) begin
      if (!present[r.handle] || slot_of[r.handle] >= heap_size)
        o.status = imh_pkg::ST_ABSENT;
      else begin
        heap_q[slot_of[r.handle]] = make_entry(r.value, r.handle);
        bubble_down(bubble_up(slot_of[r.handle]));
      end
    end
    return o;
  endfunction

  task automatic send_request(logic [1:0] op, logic signed [31:0] v, logic [9:0] h,
                              int unsigned gap = 0);
    imh_pkg::request_t r;
    r.op = op;
    r.value = v;
    r.handle = h;
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.insert(expected_results.size(), predict_heap_op(r));
    request_count++;
    if (op == imh_pkg::OP_EXTRACT) extract_count++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [9:0] free_handle();
    logic [9:0] h;
    h = 10'($urandom_range(0, imh_pkg::HANDLE_COUNT - 1));
    while (present[h]) h = h + 10'd1;
    return h;
  endfunction

  function automatic logic [9:0] live_handle();
    return heap_size == 0 ? 10'($urandom) : heap_q[$urandom_range(0, heap_size - 1)][9:0];
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $signed($urandom);
      1: return 32'sh8000_0000 + $urandom_range(0, 3);
      2: return 32'sh7fff_ffff - $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  task automatic test_edges();
    send_request(imh_pkg::OP_EXTRACT, 32'sd5, 10'd7);
    send_request(imh_pkg::OP_DECREASE, 32'sd1, 10'd3);
    send_request(imh_pkg::OP_PUSH, 32'sh7fff_ffff, 10'h3ff);
    send_request(imh_pkg::OP_PUSH, 32'sh8000_0000, 10'h000);
    send_request(imh_pkg::OP_PUSH, 32'sh8000_0000, 10'h155);
    send_request(imh_pkg::OP_PUSH, 32'sd0, 10'h2aa);
    send_request(imh_pkg::OP_PUSH, 32'sd9, 10'h000);       // handle taken
    send_request(imh_pkg::OP_DECREASE, 32'sh8000_0000, 10'h3ff);
    send_request(imh_pkg::OP_DECREASE, 32'sh7fff_ffff, 10'h000);  // raise key, sifts down
    send_request(imh_pkg::OP_DECREASE, 32'sd1, 10'h100);   // absent
    send_request(2'd3, 32'sh5555_aaaa, 10'h155);  // unused op
    send_request(2'd3, 32'shaaaa_5555, 10'h2aa);
    repeat (5) send_request(imh_pkg::OP_EXTRACT, 32'sd0, 10'd0);
    drain_results();
  endtask

  task automatic test_deep_heap();
    int i;
    for (i = 0; i < 200; i++)
      send_request(imh_pkg::OP_PUSH, $signed($urandom), 10'(i),
                   i % 4 == 0 ? $urandom_range(0, 19) : 0);
    send_request(imh_pkg::OP_DECREASE, 32'sh8000_0000, 10'd199);
    send_request(imh_pkg::OP_DECREASE, 32'sh7fff_ffff, 10'd0);
    for (i = 0; i <= 200; i++)
      send_request(imh_pkg::OP_EXTRACT, 32'sd0, 10'd0,
                   i % 4 == 0 ? $urandom_range(0, 19) : 0);
    drain_results();
  endtask

  task automatic test_random_mix();
    int i;
    int unsigned pick;
    for (i = 0; i < 330; i++) begin
      pick = $urandom_range(0, 99);
      if (i == 165) drain_results();  // hold until all results are back
      if (pick < 40)
        send_request(imh_pkg::OP_PUSH, rand_value(),
                     pick < 36 ? free_handle() : live_handle(),
                     i % 100 < 30 ? 0 : $urandom_range(0, 19));
      else if (pick < 70)
        send_request(imh_pkg::OP_EXTRACT, $signed($urandom), 10'($urandom),
                     i % 100 < 30 ? 0 : $urandom_range(0, 19));
      else if (pick < 95)
        send_request(imh_pkg::OP_DECREASE, rand_value(),
                     pick < 90 ? live_handle() : 10'($urandom),
                     i % 100 < 30 ? 0 : $urandom_range(0, 19));
      else
        send_request(2'd3, $signed($urandom), 10'($urandom), $urandom_range(0, 19));
    end
    drain_results();
  endtask

  always @(posedge clk) begin
    imh_pkg::result_t e;
    if (!rst && done) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $error("result with no request pending: min_value %0d status %0d",
               res.min_value, res.status);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (res.min_value !== e.min_value) begin
          $error("min_value: expected %0d, actual %0d", e.min_value, res.min_value);
          error_count++;
        end
        if (res.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, res.status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results pending", expected_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    request_count = 0;
    extract_count = 0;
    heap_size = 0;
    foreach (present[i]) present[i] = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_edges();
    test_deep_heap();
    test_random_mix();
    repeat (60) @(posedge clk);
    if (expected_results.size() != 0)
      $error("%0d results never arrived", expected_results.size());
    $display("covered %0d requests (%0d extracts), %0d results checked",
             request_count, extract_count, result_count);
    $display("empty, absent handle, key raise, deep sift and unused op cases exercised");
    if (error_count == 0 && expected_results.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/imh_pkg.sv
hdl/imh_ram.sv
hdl/imh_present.sv
hdl/indexed_min_heap_decrease_key.sv
tb/tb_indexed_min_heap_decrease_key.sv
